// ===== rtl/sfp_pkg.sv =====
// Shared constants, types and command/status bundles for the serial frame parser.
`timescale 1ns / 1ps

package sfp_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;
    localparam int POS_W  = 6;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL = 1'd1;

    localparam logic [BYTE_W-1:0] HEAD_RESET = 8'hAA;
    localparam logic [BYTE_W-1:0] TAIL_RESET = 8'h55;

    // controller -> datapath
    typedef struct packed {
        logic start;        // head seen: seed sum, clear fill count
        logic ld_master;
        logic ld_sub;
        logic add_sum;      // fold the current beat into the sum
        logic ld_len;
        logic wr_data;      // store payload byte, bump fill count
        logic drain_start;  // good tail: rewind read pointer
        logic rd_en;        // issue one payload read
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_head;
        logic is_tail;
        logic len_big;
        logic len_zero;
        logic fill_last;
        logic sum_ok;
        logic can_issue;
        logic last_issue;
    } t_stat;

endpackage

// ===== rtl/sfp_in_if.sv =====
// Input channel: one received byte per beat.
`timescale 1ns / 1ps

interface sfp_in_if;
    import sfp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/sfp_out_if.sv =====
// Output channel: one payload byte of an accepted frame per beat.
`timescale 1ns / 1ps

interface sfp_out_if;
    import sfp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] mst_id;
    logic [BYTE_W-1:0] sub_id;
    logic [LEN_W-1:0]  payload_len;
    logic [BYTE_W-1:0] payload_byte;
    logic [POS_W-1:0]  byte_pos;
    logic              last_flag;

    modport source (
        output valid, output mst_id, output sub_id, output payload_len,
        output payload_byte, output byte_pos, output last_flag, input ready
    );
    modport sink (
        input valid, input mst_id, input sub_id, input payload_len,
        input payload_byte, input byte_pos, input last_flag, output ready
    );
endinterface

// ===== rtl/sfp_ctrl.sv =====
// Frame parser controller: phase state machine issuing datapath commands.
`timescale 1ns / 1ps

module sfp_ctrl
    import sfp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        ST_HUNT,
        ST_MASTER,
        ST_SUB,
        ST_TYPE,
        ST_LEN,
        ST_DATA,
        ST_CSUM,
        ST_TAIL,
        ST_DRAIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   acc;

    assign o_ready = (r_state != ST_DRAIN);
    assign acc     = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_HUNT: begin
                if (acc && i_stat.is_head) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_MASTER;
                end
            end
            ST_MASTER: begin
                if (acc) begin
                    o_cmd.ld_master = 1'b1;
                    o_cmd.add_sum   = 1'b1;
                    n_state         = ST_SUB;
                end
            end
            ST_SUB: begin
                if (acc) begin
                    o_cmd.ld_sub  = 1'b1;
                    o_cmd.add_sum = 1'b1;
                    n_state       = ST_TYPE;
                end
            end
            ST_TYPE: begin
                if (acc) begin
                    o_cmd.add_sum = 1'b1;
                    n_state       = ST_LEN;
                end
            end
            ST_LEN: begin
                if (acc) begin
                    o_cmd.add_sum = 1'b1;
                    o_cmd.ld_len  = 1'b1;
                    if (i_stat.len_big) begin
                        n_state = ST_HUNT;
                    end else if (i_stat.len_zero) begin
                        n_state = ST_CSUM;
                    end else begin
                        n_state = ST_DATA;
                    end
                end
            end
            ST_DATA: begin
                if (acc) begin
                    o_cmd.wr_data = 1'b1;
                    if (i_stat.fill_last) begin
                        n_state = ST_CSUM;
                    end
                end
            end
            ST_CSUM: begin
                if (acc) begin
                    n_state = i_stat.sum_ok ? ST_TAIL : ST_HUNT;
                end
            end
            ST_TAIL: begin
                if (acc) begin
                    // the tail beat is never reused as a head
                    n_state = ST_HUNT;
                    if (i_stat.is_tail) begin
                        o_cmd.drain_start = 1'b1;
                        n_state           = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (i_stat.can_issue) begin
                    o_cmd.rd_en = 1'b1;
                    if (i_stat.last_issue) begin
                        n_state = ST_HUNT;
                    end
                end
            end
            default: begin
                n_state = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/sfp_dpath.sv =====
// Frame parser datapath: config, header fields, checksum, payload memory, output register.
`timescale 1ns / 1ps

module sfp_dpath
    import sfp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [BYTE_W-1:0]     i_rx_byte,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [BYTE_W-1:0]     o_mst_id,
    output logic [BYTE_W-1:0]     o_sub_id,
    output logic [LEN_W-1:0]      o_payload_len,
    output logic [BYTE_W-1:0]     o_payload_byte,
    output logic [POS_W-1:0]      o_byte_pos,
    output logic                  o_last_flag
);

    logic [BYTE_W-1:0] r_head;
    logic [BYTE_W-1:0] r_tail;
    logic [BYTE_W-1:0] r_master;
    logic [BYTE_W-1:0] r_sub;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  r_fill;
    logic [BYTE_W-1:0] r_sum;
    logic [LEN_W-1:0]  r_ptr;

    logic [BYTE_W-1:0] r_mem [MAX_PAYLOAD];

    // read stage: memory data plus the item's side fields
    logic              r_rd_vld;
    logic [BYTE_W-1:0] r_rd_data;
    logic [BYTE_W-1:0] r_rd_master;
    logic [BYTE_W-1:0] r_rd_sub;
    logic [LEN_W-1:0]  r_rd_len;
    logic [POS_W-1:0]  r_rd_pos;
    logic              r_rd_last;

    // output register
    logic              r_o_vld;
    logic [BYTE_W-1:0] r_o_master;
    logic [BYTE_W-1:0] r_o_sub;
    logic [LEN_W-1:0]  r_o_len;
    logic [BYTE_W-1:0] r_o_byte;
    logic [POS_W-1:0]  r_o_pos;
    logic              r_o_last;

    logic [LEN_W-1:0]  n_items;
    logic              load;

    // empty payload still yields one item
    assign n_items = (r_len == '0) ? LEN_W'(1) : r_len;
    assign load    = r_rd_vld && (!r_o_vld || i_out_ready);

    assign o_stat.is_head    = (i_rx_byte == r_head);
    assign o_stat.is_tail    = (i_rx_byte == r_tail);
    assign o_stat.len_big    = (i_rx_byte > BYTE_W'(MAX_PAYLOAD));
    assign o_stat.len_zero   = (i_rx_byte == '0);
    assign o_stat.fill_last  = ((r_fill + LEN_W'(1)) >= r_len);
    assign o_stat.sum_ok     = (i_rx_byte == r_sum);
    assign o_stat.can_issue  = !r_rd_vld || load;
    assign o_stat.last_issue = ((r_ptr + LEN_W'(1)) == n_items);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= HEAD_RESET;
            r_tail   <= TAIL_RESET;
            r_master <= '0;
            r_sub    <= '0;
            r_len    <= '0;
            r_fill   <= '0;
            r_sum    <= '0;
            r_ptr    <= '0;
            r_rd_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HEAD: r_head <= i_cfg_data;
                    CFG_TAIL: r_tail <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.start) begin
                r_sum  <= i_rx_byte;
                r_fill <= '0;
            end else if (i_cmd.add_sum || i_cmd.wr_data) begin
                r_sum <= r_sum + i_rx_byte;
            end
            if (i_cmd.ld_master) begin
                r_master <= i_rx_byte;
            end
            if (i_cmd.ld_sub) begin
                r_sub <= i_rx_byte;
            end
            if (i_cmd.ld_len) begin
                r_fill <= '0;
                r_len  <= o_stat.len_big ? '0 : i_rx_byte[LEN_W-1:0];
            end
            if (i_cmd.wr_data) begin
                r_fill <= r_fill + LEN_W'(1);
            end
            if (i_cmd.drain_start) begin
                r_ptr <= '0;
            end else if (i_cmd.rd_en) begin
                r_ptr <= r_ptr + LEN_W'(1);
            end
            if (i_cmd.rd_en) begin
                r_rd_vld <= 1'b1;
            end else if (load) begin
                r_rd_vld <= 1'b0;
            end
            if (load) begin
                r_o_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_data) begin
            r_mem[r_fill[ADDR_W-1:0]] <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data   <= r_mem[r_ptr[ADDR_W-1:0]];
            r_rd_master <= r_master;
            r_rd_sub    <= r_sub;
            r_rd_len    <= r_len;
            r_rd_pos    <= r_ptr[POS_W-1:0];
            r_rd_last   <= o_stat.last_issue;
        end
        if (load) begin
            r_o_master <= r_rd_master;
            r_o_sub    <= r_rd_sub;
            r_o_len    <= r_rd_len;
            r_o_byte   <= (r_rd_len == '0) ? '0 : r_rd_data;
            r_o_pos    <= r_rd_pos;
            r_o_last   <= r_rd_last;
        end
    end

    assign o_out_valid    = r_o_vld;
    assign o_mst_id       = r_o_master;
    assign o_sub_id       = r_o_sub;
    assign o_payload_len  = r_o_len;
    assign o_payload_byte = r_o_byte;
    assign o_byte_pos     = r_o_pos;
    assign o_last_flag    = r_o_last;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= LEN_W'(MAX_PAYLOAD))
        else $error("fill count past max payload");

    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |-> (r_ptr < n_items))
        else $error("payload read past frame end");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_o_vld)
        else $error("loaded item not presented");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && r_o_last) |->
            ((r_o_len == '0) || ((LEN_W'(r_o_pos) + LEN_W'(1)) == r_o_len)))
        else $error("last flag on wrong position");
`endif

endmodule

// ===== rtl/serial_frame_parser.sv =====
// Top level of the serial frame parser: controller, datapath and channel hookup.
`timescale 1ns / 1ps

// Byte-serial frame receiver with an 8-bit additive checksum.
// i_rx carries one received byte per beat. The parser hunts for the head
// byte, then takes master id, sub id, type, length, the payload, a checksum
// byte and a tail byte. A bad checksum, a bad tail or a length above
// MAX_PAYLOAD drops the frame silently and hunting restarts on the next beat.
// On a good tail, o_frm gives one beat per payload byte (one beat with byte 0
// for an empty payload), each carrying master id, sub id and length.
// Rate: one input beat per cycle while parsing. After the tail beat, i_rx is
// held off while the payload reads issue through the single read port of
// the payload memory, one read per cycle while a slot is free.
// After the edge that takes the tail beat, each item passes the read stage
// and the output register before o_frm.valid rises; then one beat per
// cycle while the receiver keeps ready high.
// If the receiver stalls, a read stage and the output register hold two items;
// reads pause until a slot frees, and input stays held until all reads issue.
// A new frame may start while the last items still wait on o_frm.
// Reset (i_rst_n low at a clock edge) returns to hunting, clears the header
// fields and checksum, restores head 0xAA and tail 0x55 and empties the
// output. Configuration writes take effect at the next edge, no read-back.
module serial_frame_parser
    import sfp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sfp_in_if.sink                i_rx,
    sfp_out_if.source             o_frm,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;
    logic  rx_ready;

    sfp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_rx.valid),
        .o_ready (rx_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    sfp_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_rx_byte      (i_rx.rx_byte),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_out_ready    (o_frm.ready),
        .o_out_valid    (o_frm.valid),
        .o_mst_id       (o_frm.mst_id),
        .o_sub_id       (o_frm.sub_id),
        .o_payload_len  (o_frm.payload_len),
        .o_payload_byte (o_frm.payload_byte),
        .o_byte_pos     (o_frm.byte_pos),
        .o_last_flag    (o_frm.last_flag)
    );

    // input is held off only while the payload drains
    assign i_rx.ready = rx_ready;

endmodule
